// ----- rtl/assert_macros.svh -----
// Assertion macros used by the validator RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SUV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/suv_pkg.sv -----
// Package for the strict UTF-8 validator: beat and state types, byte
// constants and the forbidden code point check. No dependencies.
`timescale 1ns / 1ps

package suv_pkg;

    localparam logic [7:0] ASCII_MIN  = 8'h00;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_90    = 8'h90;
    localparam logic [7:0] CONT_8F    = 8'h8F;

    localparam logic [20:0] NONCHAR_LO = 21'h00FDD0;
    localparam logic [20:0] NONCHAR_HI = 21'h00FDEF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [15:0] PLANE_FFFE = 16'hFFFE;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
        logic       empty_string;
    } t_in_beat;

    typedef struct packed {
        logic        err;
        logic [1:0]  pending;
        logic [7:0]  lead;
        logic [20:0] cp;
        logic [1:0]  pos;
    } t_seq_state;

    typedef struct packed {
        logic verdict_ready;
        logic string_valid;
    } t_result;

    function automatic logic is_forbidden(input logic [20:0] cp);
        return (cp == 21'd0)
            || (cp >= NONCHAR_LO && cp <= NONCHAR_HI)
            || (cp <= CP_MAX && cp[15:0] >= PLANE_FFFE);
    endfunction

endpackage

// ----- rtl/suv_in_stage.sv -----
// Input register of the validator: captures one beat and holds it until the
// decode step can advance. Depends on suv_pkg.
`timescale 1ns / 1ps

module suv_in_stage
    import suv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    input  logic       i_empty_string,
    input  logic       i_advance,
    output logic       o_beat_valid,
    output t_in_beat   o_beat
);

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     in_accept;

    assign o_in_stall = r_valid && !i_advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign n_valid    = in_accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_beat.text_byte    <= i_text_byte;
            r_beat.final_byte   <= i_final_byte;
            r_beat.empty_string <= i_empty_string;
        end
    end

    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

endmodule

// ----- rtl/suv_step.sv -----
// Combinational decode of one byte against the current sequence state:
// gives the next state and the result of the beat. Depends on suv_pkg.
`timescale 1ns / 1ps

module suv_step
    import suv_pkg::*;
(
    input  t_in_beat   i_beat,
    input  t_seq_state i_state,
    output t_seq_state o_next,
    output t_result    o_result
);

    logic [7:0]  b;
    logic [20:0] cont_cp;
    logic [1:0]  cont_pending;
    logic        range_fail;
    t_seq_state  err_state;

    assign b            = i_beat.text_byte;
    assign cont_cp      = {i_state.cp[14:0], b[5:0]};
    assign cont_pending = i_state.pending - 2'd1;

    always_comb begin
        err_state     = '0;
        err_state.err = 1'b1;
    end

    assign range_fail = (i_state.pos == 2'd1)
        && ((i_state.lead == LEAD_E0 && b < CONT_A0)
         || (i_state.lead == LEAD_ED && b >= CONT_A0)
         || (i_state.lead == LEAD_F0 && b < CONT_90)
         || (i_state.lead == LEAD_F4 && b > CONT_8F));

    always_comb begin
        o_next   = i_state;
        o_result = '0;
        if (i_beat.empty_string) begin
            o_next                 = '0;
            o_result.verdict_ready = 1'b1;
            o_result.string_valid  = 1'b1;
        end else begin
            if (!i_state.err) begin
                if (i_state.pending == 2'd0) begin
                    unique case (b) inside
                        [ASCII_MIN:ASCII_MAX]: begin
                            if (is_forbidden({13'd0, b})) begin
                                o_next = err_state;
                            end
                        end
                        [LEAD2_MIN:LEAD2_MAX]: begin
                            o_next.pending = 2'd1;
                            o_next.cp      = {16'd0, b[4:0]};
                            o_next.lead    = b;
                            o_next.pos     = 2'd1;
                        end
                        [LEAD3_MIN:LEAD3_MAX]: begin
                            o_next.pending = 2'd2;
                            o_next.cp      = {17'd0, b[3:0]};
                            o_next.lead    = b;
                            o_next.pos     = 2'd1;
                        end
                        [LEAD4_MIN:LEAD4_MAX]: begin
                            o_next.pending = 2'd3;
                            o_next.cp      = {18'd0, b[2:0]};
                            o_next.lead    = b;
                            o_next.pos     = 2'd1;
                        end
                        default: begin
                            o_next = err_state;
                        end
                    endcase
                end else begin
                    if ((b & CONT_MASK) != CONT_TAG || range_fail) begin
                        o_next = err_state;
                    end else if (cont_pending == 2'd0) begin
                        o_next = is_forbidden(cont_cp) ? err_state : '0;
                    end else begin
                        o_next.cp      = cont_cp;
                        o_next.pending = cont_pending;
                        o_next.pos     = i_state.pos + 2'd1;
                    end
                end
            end
            if (i_beat.final_byte) begin
                o_result.verdict_ready = 1'b1;
                o_result.string_valid  = !o_next.err && (o_next.pending == 2'd0);
                o_next                 = '0;
            end
        end
    end

endmodule

// ----- rtl/strict_utf8_validator_unit.sv -----
// Strict UTF-8 validator, top level. Takes one byte of a string per beat and
// gives one result beat per byte; the result of the last byte carries the
// verdict. A beat passes an input register, is decoded combinationally against
// the sequence state and lands in a result register, so the block accepts
// one byte every cycle while the output is not stalled. While a result waits,
// one more byte can be taken into the input register before the input stalls.
// Uses suv_pkg, suv_in_stage, suv_step and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module strict_utf8_validator_unit
    import suv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    input  logic       i_empty_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_verdict_ready,
    output logic       o_string_valid
);

    logic       beat_valid;
    t_in_beat   beat;
    logic       advance;
    t_seq_state r_state;
    t_seq_state n_state;
    t_result    step_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       n_out_valid;

    assign advance = beat_valid && (!r_out_valid || !i_out_stall);

    suv_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .i_empty_string (i_empty_string),
        .i_advance      (advance),
        .o_beat_valid   (beat_valid),
        .o_beat         (beat)
    );

    suv_step u_step (
        .i_beat   (beat),
        .i_state  (r_state),
        .o_next   (n_state),
        .o_result (step_result)
    );

    assign n_out_valid = advance || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict_ready = r_result.verdict_ready;
    assign o_string_valid  = r_result.string_valid;

    `SUV_ASSERT_NOW(a_err_no_pending, i_clk, i_rst_n, r_state.err, r_state.pending == 2'd0, "error state holds a pending sequence")
    `SUV_ASSERT_NOW(a_pending_has_pos, i_clk, i_rst_n, r_state.pending != 2'd0, r_state.pos != 2'd0, "pending sequence without a position")
    `SUV_ASSERT_NEXT(a_verdict_clears, i_clk, i_rst_n, advance && step_result.verdict_ready, r_state == '0, "state not cleared after a verdict")
    `SUV_ASSERT_NOW(a_valid_has_verdict, i_clk, i_rst_n, o_out_valid && o_string_valid, o_verdict_ready, "string_valid without verdict_ready")
    `SUV_ASSERT_NOW(a_empty_no_stall, i_clk, i_rst_n, !beat_valid, !o_in_stall, "input stalled with an empty input register")

endmodule

// ----- tb/tb_strict_utf8_validator_unit.sv -----
// Self-checking testbench for strict_utf8_validator_unit: directed byte table, then random
// strings of encoded code points, noise and broken sequences, checked against a byte decoder.
// Depends on suv_pkg and the validator RTL.
`timescale 1ns / 1ps

module tb_strict_utf8_validator_unit;
    import suv_pkg::*;

    localparam int RANDOM_BEATS = 1100;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] ASCII_TOP     = 8'h7F;
    localparam logic [7:0] TWO_LEAD_LO   = 8'hC2;
    localparam logic [7:0] TWO_LEAD_HI   = 8'hDF;
    localparam logic [7:0] THREE_LEAD_LO = 8'hE0;
    localparam logic [7:0] THREE_LEAD_HI = 8'hEF;
    localparam logic [7:0] FOUR_LEAD_LO  = 8'hF0;
    localparam logic [7:0] FOUR_LEAD_HI  = 8'hF4;
    localparam logic [7:0] SURR_LEAD     = 8'hED;
    localparam logic [7:0] CONT_FLOOR_E0 = 8'hA0;
    localparam logic [7:0] CONT_FLOOR_F0 = 8'h90;
    localparam logic [7:0] CONT_CEIL_F4  = 8'h8F;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
        logic       empty_string;
        logic       typed;
        logic       verdict_ready;
        logic       string_valid;
    } t_dir_row;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_byte;
    logic       final_byte;
    logic       empty_string;
    logic       out_valid;
    logic       out_stall;
    logic       verdict_ready;
    logic       string_valid;

    logic [1:0]  seq_pending = '0;
    logic [7:0]  seq_lead    = '0;
    logic [20:0] seq_cp      = '0;
    logic [1:0]  seq_pos     = '0;
    logic        str_err     = 1'b0;

    t_result    verdict_q [$];
    logic [7:0] str_bytes [$];
    int         mismatches = 0;
    int         beats_sent = 0;
    logic       tx_idle = 1'b1;
    logic       long_hold_req = 1'b0;

    t_dir_row dir_tab [27] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{8'h41, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'h7F, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{8'h80, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hC2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1},
        '{8'hE0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hEF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hB7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h90, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{8'hF4, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hBD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    strict_utf8_validator_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_final_byte   (final_byte),
        .i_empty_string (empty_string),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_verdict_ready(verdict_ready),
        .o_string_valid (string_valid)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic cp_is_reserved(input logic [20:0] cp);
        return (cp == 21'd0)
            || (cp >= 21'h00FDD0 && cp <= 21'h00FDEF)
            || (cp <= 21'h10FFFF && cp[15:1] == 15'h7FFF);
    endfunction

    function automatic void drop_sequence();
        seq_pending = '0;
        seq_lead    = '0;
        seq_cp      = '0;
        seq_pos     = '0;
    endfunction

    function automatic void latch_error();
        str_err = 1'b1;
        drop_sequence();
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endfunction

    function automatic void add_verdict(input t_result r);
        verdict_q = {verdict_q, r};
    endfunction

    function automatic t_result utf8_predict(input logic [7:0] b, input logic fin,
                                             input logic emp);
        t_result r;
        r = '0;
        if (emp) begin
            drop_sequence();
            str_err = 1'b0;
            r.verdict_ready = 1'b1;
            r.string_valid  = 1'b1;
            return r;
        end
        if (!str_err) begin
            if (seq_pending == 2'd0) begin
                if (b <= ASCII_TOP) begin
                    if (cp_is_reserved({13'd0, b})) latch_error();
                end else if (b >= TWO_LEAD_LO && b <= TWO_LEAD_HI) begin
                    seq_pending = 2'd1;
                    seq_cp      = {16'd0, b[4:0]};
                end else if (b >= THREE_LEAD_LO && b <= THREE_LEAD_HI) begin
                    seq_pending = 2'd2;
                    seq_cp      = {17'd0, b[3:0]};
                end else if (b >= FOUR_LEAD_LO && b <= FOUR_LEAD_HI) begin
                    seq_pending = 2'd3;
                    seq_cp      = {18'd0, b[2:0]};
                end else begin
                    latch_error();
                end
                if (seq_pending != 2'd0) begin
                    seq_lead = b;
                    seq_pos  = 2'd1;
                end
            end else if (b[7:6] != 2'b10) begin
                latch_error();
            end else if (seq_pos == 2'd1 &&
                         ((seq_lead == THREE_LEAD_LO && b < CONT_FLOOR_E0) ||
                          (seq_lead == SURR_LEAD && b >= CONT_FLOOR_E0) ||
                          (seq_lead == FOUR_LEAD_LO && b < CONT_FLOOR_F0) ||
                          (seq_lead == FOUR_LEAD_HI && b > CONT_CEIL_F4))) begin
                latch_error();
            end else begin
                seq_cp      = {seq_cp[14:0], b[5:0]};
                seq_pending = seq_pending - 2'd1;
                seq_pos     = seq_pos + 2'd1;
                if (seq_pending == 2'd0) begin
                    if (cp_is_reserved(seq_cp)) latch_error();
                    else drop_sequence();
                end
            end
        end
        if (fin) begin
            r.verdict_ready = 1'b1;
            r.string_valid  = !str_err && seq_pending == 2'd0;
            drop_sequence();
            str_err = 1'b0;
        end
        return r;
    endfunction

    function automatic int natural_len(input logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic void append_code_point(input logic [20:0] cp, input int n);
        case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic fin, input logic emp,
                             input logic typed, input logic want_ready,
                             input logic want_valid);
        int      gap;
        t_result r;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        text_byte    <= b;
        final_byte   <= fin;
        empty_string <= emp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = utf8_predict(b, fin, emp);
        if (typed) begin
            r.verdict_ready = want_ready;
            r.string_valid  = want_valid;
        end
        add_verdict(r);
        beats_sent++;
    endtask

    task automatic release_bus();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_verdicts_drained();
        while (verdict_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_random_string();
        int          kind;
        int          nchar;
        int          sel;
        int          n;
        int          at;
        logic [20:0] cp;
        kind    = $urandom_range(0, 19);
        tx_idle = ($urandom_range(0, 3) != 0);
        str_bytes.delete();
        if (kind == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                      1'b0, 1'b0, 1'b0);
            return;
        end
        if (kind <= 2) begin
            nchar = $urandom_range(1, 10);
            repeat (nchar) add_byte(8'($urandom_range(0, 255)));
        end else begin
            nchar = $urandom_range(1, 8);
            repeat (nchar) begin
                sel = (kind >= 13 && kind <= 15) ? $urandom_range(0, 19) : $urandom_range(0, 14);
                if (sel <= 5) begin
                    cp = 21'($urandom_range(1, 127));
                    n  = 1;
                end else if (sel <= 8) begin
                    cp = 21'($urandom_range(21'h80, 21'h7FF));
                    n  = 2;
                end else if (sel <= 11) begin
                    cp = 21'($urandom_range(21'h800, 21'hFFFF));
                    n  = 3;
                end else if (sel <= 14) begin
                    cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                    n  = 4;
                end else if (sel == 15) begin
                    cp = 21'(($urandom_range(0, 16) << 16) | 21'hFFFE | $urandom_range(0, 1));
                    n  = natural_len(cp);
                end else if (sel == 16) begin
                    cp = $urandom_range(0, 1) ? 21'(21'hFDD0 + $urandom_range(0, 31))
                                              : 21'(21'hD800 + $urandom_range(0, 2047));
                    n  = 3;
                end else if (sel == 17) begin
                    cp = 21'($urandom_range(0, 2047));
                    n  = (cp < 21'h80) ? $urandom_range(2, 4) : $urandom_range(3, 4);
                end else if (sel == 18) begin
                    cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
                    n  = 4;
                end else begin
                    cp = '0;
                    n  = 1;
                end
                append_code_point(cp, n);
            end
        end
        if (kind == 17 || kind == 18) begin
            at = $urandom_range(0, str_bytes.size() - 1);
            str_bytes[at] = 8'($urandom_range(0, 255));
        end else if (kind == 19) begin
            void'(str_bytes.pop_back());
            if (str_bytes.size() == 0) add_byte(8'hE1);
        end
        foreach (str_bytes[i]) begin
            send_beat(str_bytes[i], (kind != 16) && (i == str_bytes.size() - 1), 1'b0,
                      1'b0, 1'b0, 1'b0);
        end
        if (kind == 16) begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                      1'b0, 1'b0, 1'b0);
        end
    endtask

    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result beat ready=%b valid=%b",
                             $realtime, verdict_ready, string_valid);
            end else begin
                want = verdict_q.pop_front();
                if (verdict_ready !== want.verdict_ready ||
                    string_valid !== want.string_valid) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch ready exp %b got %b, valid exp %b got %b",
                                 $realtime, want.verdict_ready, verdict_ready,
                                 want.string_valid, string_valid);
                end
            end
        end
    end

    initial begin
        int   hold;
        logic rx_idle;
        out_stall = 1'b0;
        rx_idle   = 1'b1;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 24) == 0) rx_idle = ~rx_idle;
            hold = rx_idle ? $urandom_range(0, 6) : 0;
            if (long_hold_req) begin
                hold          = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int   random_goal;
        logic hold_done;
        logic pause_done;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        text_byte    = '0;
        final_byte   = 1'b0;
        empty_string = 1'b0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            send_beat(dir_tab[k].text_byte, dir_tab[k].final_byte, dir_tab[k].empty_string,
                      dir_tab[k].typed, dir_tab[k].verdict_ready, dir_tab[k].string_valid);
        end
        release_bus();
        wait_verdicts_drained();

        random_goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_goal) begin
            if (!hold_done && beats_sent > random_goal - 700) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
                tx_idle       = 1'b0;
            end
            if (!pause_done && beats_sent > random_goal - 400) begin
                release_bus();
                wait_verdicts_drained();
                pause_done = 1'b1;
            end
            send_random_string();
        end
        release_bus();
        wait_verdicts_drained();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
